// File: hdl/frt_pkg.sv
package frt_pkg;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int BYTES_W  = 20;
  localparam int FNUM_W   = 16;
  localparam int INDEX_W  = 11;
  localparam int OFFSET_W = 20;

  // received map is kept as rows of WORD_W flags
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  // frame count numerator: total_bytes plus (frame size - 1)
  localparam int NUM_W = 21;

  typedef enum logic [OP_W-1:0] {
    OP_INIT = 2'd0,
    OP_DATA = 2'd1,
    OP_DONE = 2'd2,
    OP_TICK = 2'd3
  } frt_op_e;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_STORE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_REQ   = 2'd3
  } frt_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_INIT_REPLY,
    ST_CHK,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_DONE_ACK,
    ST_REQ
  } frt_state_e;

  typedef struct packed {
    frt_kind_e             kind;
    logic                  accepted;
    logic [INDEX_W-1:0]    frame_index;
    logic [OFFSET_W-1:0]   byte_offset;
    logic                  complete;
    logic                  last;
  } frt_res_t;

endpackage

// File: hdl/frt_req_if.sv
interface frt_req_if;
  import frt_pkg::*;

  logic                     valid;
  logic                     ready;
  frt_op_e                  op;
  logic [BYTES_W-1:0]       total_bytes;
  logic [FNUM_W-1:0]        frame_number;

  modport source (output valid, op, total_bytes, frame_number, input ready);
  modport sink (input valid, op, total_bytes, frame_number, output ready);

endinterface

// File: hdl/frt_res_if.sv
interface frt_res_if;
  import frt_pkg::*;

  logic                     valid;
  logic                     ready;
  frt_kind_e                kind;
  logic                     accepted;
  logic [INDEX_W-1:0]       frame_index;
  logic [OFFSET_W-1:0]      byte_offset;
  logic                     complete;
  logic                     last;

  modport source (output valid, kind, accepted, frame_index, byte_offset, complete, last,
                  input ready);
  modport sink (input valid, kind, accepted, frame_index, byte_offset, complete, last,
                output ready);

endinterface

// File: hdl/frt_ram.sv
module frt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/frame_reassembly_tracker_unit.sv
// Receive-side frame tracker for a selective-repeat transfer. One request is taken at a time;
// ready is high only while the block is idle, and results leave through an output register
// that holds one result. Init gets the frame count from a reciprocal multiply on the shared
// multiplier that also forms byte offsets, then replies. A data request for a new frame reads
// the map row, then marks it and issues the store result, then rescans the received map with
// one shared 64-bit zero search, one row per cycle starting at the row of the earliest missing
// frame. A frame already received takes the same path without the store result. Stale or
// out-of-range frames, and data with no session open, are dropped without a result. Done
// replies, then requests the earliest missing frame when frames are still missing; a timeout
// tick issues that request, or is dropped before any data. A stalled output holds each step
// that issues a result until the output register is free.
// Completion clears the map at once through per-row valid flags; there is no clearing pass.
module frame_reassembly_tracker_unit
  import frt_pkg::*;
#(
  parameter int MAX_FRAMES  = 1024,
  parameter int FRAME_BYTES = 1022
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  frt_req_if.sink   req_i,
  frt_res_if.source res_o
);

  localparam int ROWS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = $clog2(MAX_FRAMES + 1);
  localparam int PW0  = ((AW + BIT_W) > CW) ? (AW + BIT_W) : CW;
  localparam int XW   = ((PW0 > FNUM_W) ? PW0 : FNUM_W) + 1;

  // floor(num * RCP >> DIV_SH) equals floor(num / FRAME_BYTES) for any NUM_W-bit num
  localparam int              FB_LOG = $clog2(FRAME_BYTES);
  localparam int              DIV_SH = NUM_W + FB_LOG;
  localparam int              RCP_W  = NUM_W + 1;
  localparam longint unsigned RCP    =
    ((64'd1 << DIV_SH) + 64'(FRAME_BYTES) - 64'd1) / 64'(FRAME_BYTES);
  localparam int              MW     = NUM_W + RCP_W;

  frt_state_e state_q, state_d;

  logic [CW-1:0]     fc_q, fc_d;
  logic [CW-1:0]     em_q, em_d;
  logic              open_q, open_d;
  logic              seen_q, seen_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [FNUM_W-1:0] fnum_q, fnum_d;
  logic [AW-1:0]     row_q, row_d;
  logic [ROWS-1:0]   row_vld_q, row_vld_d;
  logic              rd_vld_q, rd_vld_d;
  logic              out_vld_q;
  frt_res_t          out_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              out_free;
  logic              emit;
  frt_res_t          emit_res;

  logic              fnum_ok;
  logic [WORD_W-1:0] eff_word;
  logic              frame_bit;
  logic [AW-1:0]     em_row;

  logic [WORD_W-1:0] zero_flags, zero_oh;
  logic              zero_any;
  logic [BIT_W-1:0]  zero_pos;
  logic [XW-1:0]     cand, next_base, fc_x;
  logic              scan_end;

  logic              init_ok;
  logic              all_in;

  logic [XW-1:0]     mul_idx;
  logic [NUM_W-1:0]  mul_a;
  logic [RCP_W-1:0]  mul_b;
  logic [MW-1:0]     mul_prod;

  frt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ROWS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_vld_q || res_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign fnum_ok = (XW'(req_i.frame_number) < XW'(fc_q)) &&
                   (XW'(req_i.frame_number) >= XW'(em_q));

  // a row never written since the last clear reads as all missing
  assign eff_word  = rd_vld_q ? ram_rdata : '0;
  assign frame_bit = eff_word[fnum_q[BIT_W-1:0]];
  assign em_row    = AW'(XW'(em_q) >> BIT_W);

  // first missing frame within the current row
  assign zero_flags = ~eff_word;
  assign zero_oh    = zero_flags & (~zero_flags + WORD_W'(1));
  assign zero_any   = |zero_flags;

  always_comb begin
    zero_pos = '0;
    for (int b = 0; b < BIT_W; b++) begin
      for (int i = 0; i < WORD_W; i++) begin
        if (((i >> b) & 1) == 1) begin
          zero_pos[b] = zero_pos[b] | zero_oh[i];
        end
      end
    end
  end

  assign fc_x      = XW'(fc_q);
  assign cand      = XW'({row_q, zero_pos});
  assign next_base = XW'({row_q, BIT_W'(0)}) + XW'(WORD_W);
  assign scan_end  = zero_any || (next_base >= fc_x);

  assign init_ok = (num_q <= NUM_W'(MAX_FRAMES));
  assign all_in  = (em_q >= fc_q);

  // shared multiplier: frame count during init, byte offsets otherwise
  assign mul_idx  = (state_q == ST_CHK) ? XW'(fnum_q) : XW'(em_q);
  assign mul_a    = (state_q == ST_DIV) ? num_q : NUM_W'(mul_idx);
  assign mul_b    = (state_q == ST_DIV) ? RCP_W'(RCP) : RCP_W'(FRAME_BYTES);
  assign mul_prod = MW'(mul_a) * MW'(mul_b);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (req_i.op)
            OP_INIT: state_d = ST_DIV;
            OP_DATA: state_d = (open_q && fnum_ok) ? ST_CHK : ST_IDLE;
            OP_DONE: state_d = ST_DONE_ACK;
            OP_TICK: state_d = seen_q ? ST_REQ : ST_IDLE;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: state_d = ST_INIT_REPLY;
      ST_INIT_REPLY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CHK: begin
        if (frame_bit || out_free) begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (scan_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE_ACK: begin
        if (out_free) begin
          state_d = all_in ? ST_IDLE : ST_REQ;
        end
      end
      ST_REQ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fc_d      = fc_q;
    em_d      = em_q;
    open_d    = open_q;
    seen_d    = seen_q;
    num_d     = num_q;
    fnum_d    = fnum_q;
    row_d     = row_q;
    row_vld_d = row_vld_q;
    ram_we    = 1'b0;
    ram_waddr = AW'(fnum_q >> BIT_W);
    ram_wdata = eff_word | (WORD_W'(1) << fnum_q[BIT_W-1:0]);
    ram_re    = 1'b0;
    ram_raddr = row_q;
    emit      = 1'b0;
    emit_res  = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          fnum_d = req_i.frame_number;
          num_d  = NUM_W'(req_i.total_bytes) + NUM_W'(FRAME_BYTES - 1);
          if (req_i.op == OP_DATA && open_q) begin
            seen_d = 1'b1;
            if (fnum_ok) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(req_i.frame_number >> BIT_W);
            end
          end
        end
      end
      ST_DIV: begin
        num_d = NUM_W'(mul_prod >> DIV_SH);
      end
      ST_INIT_REPLY: begin
        if (out_free) begin
          emit              = 1'b1;
          emit_res.kind     = KIND_INIT;
          emit_res.accepted = init_ok;
          emit_res.last     = 1'b1;
          if (init_ok) begin
            fc_d   = CW'(num_q);
            em_d   = '0;
            open_d = 1'b1;
          end
        end
      end
      ST_CHK: begin
        row_d = em_row;
        if (!frame_bit && out_free) begin
          ram_we                 = 1'b1;
          row_vld_d[ram_waddr]   = 1'b1;
          emit                   = 1'b1;
          emit_res.kind          = KIND_STORE;
          emit_res.frame_index   = INDEX_W'(fnum_q);
          emit_res.byte_offset   = mul_prod[OFFSET_W-1:0];
          emit_res.last          = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        ram_re = 1'b1;
      end
      ST_SCAN_EV: begin
        if (zero_any) begin
          em_d = (cand < fc_x) ? CW'(cand) : fc_q;
        end else if (next_base >= fc_x) begin
          em_d = fc_q;
        end else begin
          row_d     = row_q + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = row_q + AW'(1);
        end
      end
      ST_DONE_ACK: begin
        if (out_free) begin
          emit              = 1'b1;
          emit_res.kind     = KIND_DONE;
          emit_res.complete = all_in;
          emit_res.last     = all_in;
          if (all_in) begin
            row_vld_d = '0;
            em_d      = '0;
            fc_d      = '0;
            open_d    = 1'b0;
            seen_d    = 1'b0;
          end
        end
      end
      ST_REQ: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_res.kind        = KIND_REQ;
          emit_res.frame_index = INDEX_W'(em_q);
          emit_res.byte_offset = mul_prod[OFFSET_W-1:0];
          emit_res.last        = 1'b1;
        end
      end
      default: ;
    endcase

    rd_vld_d = ram_re ? row_vld_q[ram_raddr] : rd_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fc_q      <= '0;
      em_q      <= '0;
      open_q    <= 1'b0;
      seen_q    <= 1'b0;
      row_q     <= '0;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fc_q      <= fc_d;
      em_q      <= em_d;
      open_q    <= open_d;
      seen_q    <= seen_d;
      row_q     <= row_d;
      row_vld_q <= row_vld_d;
      rd_vld_q  <= rd_vld_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    fnum_q <= fnum_d;
    if (emit) begin
      out_q <= emit_res;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.accepted    = out_q.accepted;
  assign res_o.frame_index = out_q.frame_index;
  assign res_o.byte_offset = out_q.byte_offset;
  assign res_o.complete    = out_q.complete;
  assign res_o.last        = out_q.last;

`ifndef NO_ASSERTIONS
  a_em_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_q <= fc_q)
    else $error("earliest missing frame past frame count");

  a_fc_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CW'(MAX_FRAMES))
    else $error("frame count exceeds map size");

  a_seen_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> !seen_q)
    else $error("data seen flag set without open session");

  a_complete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_res.kind == KIND_DONE && emit_res.complete)
      |=> (!open_q && em_q == '0 && fc_q == '0 && row_vld_q == '0))
    else $error("session state not cleared on completion");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_vld_q || res_o.ready))
    else $error("result written over a pending result");
`endif

endmodule
